FILE: design/stb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_pkg
// shared types and constants of the soft timer bank with led blinker
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int REQ_W  = 3;
  localparam int ID_W   = 3;
  localparam int CFG_W  = 16;
  localparam int RIDX_W = 3;
  localparam int AR_W   = 5;
  localparam int OUT_W  = 16;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_START  = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_CHECK  = 3'd3,
    REQ_STATUS = 3'd4,
    REQ_LED    = 3'd5
  } stb_req_e;

  // register indexes, periods sit at 0 up to the timer count less one
  localparam logic [RIDX_W-1:0] REG_AUTO_RELOAD = 3'd5;
  localparam logic [RIDX_W-1:0] REG_BLINK_SLOW  = 3'd6;
  localparam logic [RIDX_W-1:0] REG_BLINK_FAST  = 3'd7;

  localparam logic [CFG_W-1:0] PERIOD_RESET     = 16'd100;
  localparam logic [CFG_W-1:0] BLINK_SLOW_RESET = 16'd50;
  localparam logic [CFG_W-1:0] BLINK_FAST_RESET = 16'd12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_EXEC,
    ST_FINISH
  } stb_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic tick_step;
    logic exec;
    logic load_out;
  } stb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic new_is_tick;
    logic last_slot;
    logic out_busy;
  } stb_sts_t;

endpackage
`default_nettype wire

FILE: design/stb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_ctrl
// sequencer: accept a word, walk the tick slots or run one command, hand off
// ----------------------------------------------------------------------------
module stb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire stb_pkg::stb_sts_t sts_i,
  output stb_pkg::stb_cmd_t     cmd_o,
  output logic                  in_stall_o
);
  import stb_pkg::*;

  stb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.new_is_tick ? ST_TICK : ST_EXEC;
        end
      end
      ST_TICK: begin
        if (sts_i.last_slot) begin
          state_d = ST_FINISH;
        end
      end
      ST_EXEC: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_TICK:   cmd_o.tick_step = 1'b1;
      ST_EXEC:   cmd_o.exec      = 1'b1;
      ST_FINISH: cmd_o.load_out  = !sts_i.out_busy;
      default:   cmd_o           = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_TICK || state_q == ST_EXEC))
    else $error("accepted word did not start work");
  a_exec_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> state_q == ST_FINISH)
    else $error("command took more than one cycle");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == ST_IDLE)
    else $error("result handoff did not return to idle");
`endif

endmodule
`default_nettype wire

FILE: design/stb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_datapath
// timer state, shared decrementer, command execution and result register
// ----------------------------------------------------------------------------
module stb_datapath #(
  parameter int NUM_TIMERS  = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire stb_pkg::stb_cmd_t                      cmd_i,
  output stb_pkg::stb_sts_t                           sts_o,
  input  wire logic [stb_pkg::REQ_W-1:0]              req_type_i,
  input  wire logic [stb_pkg::ID_W-1:0]               timer_id_i,
  input  wire logic                                   fast_rate_i,
  input  wire logic [NUM_TIMERS-1:0][stb_pkg::CFG_W-1:0] period_i,
  input  wire logic [NUM_TIMERS-1:0]                  ar_mask_i,
  input  wire logic [stb_pkg::CFG_W-1:0]              blink_slow_i,
  input  wire logic [stb_pkg::CFG_W-1:0]              blink_fast_i,
  input  wire logic                                   out_stall_i,
  output logic                                        out_valid_o,
  output logic                                        expired_o,
  output logic [stb_pkg::OUT_W-1:0]                   remaining_o,
  output logic                                        running_o,
  output logic                                        led_level_o,
  output logic                                        id_ok_o
);
  import stb_pkg::*;

  localparam int IDX_W = $clog2(NUM_TIMERS + 1);
  localparam int TW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] count_q;
  logic [NUM_TIMERS-1:0]                  on_q, flag_q;
  logic [COUNT_WIDTH-1:0]                 led_count_q, led_reload_q;
  logic                                   led_out_q;
  logic [IDX_W-1:0]                       idx_q;
  logic [REQ_W-1:0]                       req_q;
  logic                                   fast_q, ok_q;
  logic                                   res_exp_q, res_run_q;
  logic [OUT_W-1:0]                       res_rem_q;
  logic                                   out_valid_q;

  logic [TW-1:0]          tidx;
  logic                   is_led, hit, ok_in;
  logic [COUNT_WIDTH-1:0] cur, dec, reload, led_sel;
  logic [ID_W-1:0]        id_m1;

  assign tidx    = idx_q[TW-1:0];
  assign is_led  = (idx_q == IDX_W'(NUM_TIMERS));
  assign ok_in   = (timer_id_i != '0) && (timer_id_i <= ID_W'(NUM_TIMERS));
  assign id_m1   = timer_id_i - ID_W'(1);
  assign reload  = COUNT_WIDTH'(period_i[tidx]);
  assign led_sel = COUNT_WIDTH'(fast_q ? blink_fast_i : blink_slow_i);

  // shared decrementer for timer slots and the led slot
  always_comb begin
    cur = is_led ? led_count_q : count_q[tidx];
    dec = (cur != '0) ? cur - COUNT_WIDTH'(1) : cur;
    hit = (dec == '0);
  end

  assign sts_o.new_is_tick = (req_type_i == REQ_TICK);
  assign sts_o.last_slot   = is_led;
  assign sts_o.out_busy    = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      on_q         <= '0;
      flag_q       <= '0;
      led_count_q  <= COUNT_WIDTH'(BLINK_FAST_RESET);
      led_reload_q <= COUNT_WIDTH'(BLINK_FAST_RESET);
      led_out_q    <= 1'b0;
      idx_q        <= '0;
    end else begin
      if (cmd_i.accept) begin
        idx_q <= (req_type_i == REQ_TICK) ? '0 : IDX_W'(id_m1);
      end
      if (cmd_i.tick_step) begin
        idx_q <= idx_q + IDX_W'(1);
        if (is_led) begin
          led_count_q <= hit ? led_reload_q : dec;
          if (hit) begin
            led_out_q <= !led_out_q;
          end
        end else if (on_q[tidx]) begin
          // expiry: reload with auto-reload, otherwise park at zero and stop
          if (hit) begin
            flag_q[tidx]  <= 1'b1;
            on_q[tidx]    <= ar_mask_i[tidx];
            count_q[tidx] <= ar_mask_i[tidx] ? reload : '0;
          end else begin
            count_q[tidx] <= dec;
          end
        end
      end
      if (cmd_i.exec) begin
        unique case (req_q)
          REQ_START: begin
            if (ok_q) begin
              count_q[tidx] <= reload;
              flag_q[tidx]  <= 1'b0;
              on_q[tidx]    <= 1'b1;
            end
          end
          REQ_STOP: begin
            if (ok_q) begin
              count_q[tidx] <= '0;
              flag_q[tidx]  <= 1'b0;
              on_q[tidx]    <= 1'b0;
            end
          end
          REQ_CHECK: begin
            if (ok_q) begin
              flag_q[tidx] <= 1'b0;
            end
          end
          REQ_LED: begin
            led_reload_q <= led_sel;
            led_count_q  <= led_sel;
          end
          default: ;
        endcase
      end
    end
  end

  // latched word and pending result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q     <= req_type_i;
      fast_q    <= fast_rate_i;
      ok_q      <= ok_in;
      res_exp_q <= 1'b0;
      res_run_q <= 1'b0;
      res_rem_q <= '0;
    end
    if (cmd_i.exec && ok_q) begin
      if (req_q == REQ_CHECK) begin
        res_exp_q <= flag_q[tidx];
      end
      if (req_q == REQ_STATUS) begin
        res_rem_q <= OUT_W'(count_q[tidx]);
        res_run_q <= on_q[tidx];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      expired_o   <= res_exp_q;
      remaining_o <= res_rem_q;
      running_o   <= res_run_q;
      led_level_o <= led_out_q;
      id_ok_o     <= ok_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("result not shown after handoff");
  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_step |-> idx_q <= IDX_W'(NUM_TIMERS))
    else $error("tick slot index out of range");
  a_exec_not_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> req_q != REQ_TICK)
    else $error("tick word sent to command path");
`endif

endmodule
`default_nettype wire

FILE: design/soft_timer_bank_with_blinker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: a command word is accepted, executed and then loaded into the result register; a tick
//   word is accepted, then one decrementer visits each timer and then the led counter,
//   one slot per cycle, before the result register is loaded
// throughput: one word at a time, the next word is taken once the result is handed off
// reset: async active low; counts, enables and flags clear, led counter and reload
//   load the fast rate reset value, registers take their reset values
// ----------------------------------------------------------------------------
// soft_timer_bank_with_blinker_unit
// bank of numbered down-count timers with an led blink divider
// ----------------------------------------------------------------------------
module soft_timer_bank_with_blinker_unit #(
  parameter int NUM_TIMERS  = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [stb_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [stb_pkg::ID_W-1:0]     timer_id_i,
  input  wire logic                         fast_rate_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              expired_o,
  output logic [stb_pkg::OUT_W-1:0]         remaining_o,
  output logic                              running_o,
  output logic                              led_level_o,
  output logic                              id_ok_o,
  // register write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [stb_pkg::RIDX_W-1:0]   cfg_index_i,
  input  wire logic [stb_pkg::CFG_W-1:0]    cfg_data_i
);
  import stb_pkg::*;

  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // configuration registers
  logic [NUM_TIMERS-1:0][CFG_W-1:0] period_q;
  logic [AR_W-1:0]                  ar_mask_q;
  logic [CFG_W-1:0]                 blink_slow_q, blink_fast_q;

  stb_cmd_t cmd;
  stb_sts_t sts;

  // writes are always taken; indexes past the timer count and below the
  // auto-reload register fall through and are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= {NUM_TIMERS{PERIOD_RESET}};
      ar_mask_q    <= '0;
      blink_slow_q <= BLINK_SLOW_RESET;
      blink_fast_q <= BLINK_FAST_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i < RIDX_W'(NUM_TIMERS)) begin
        period_q[cfg_index_i[TW-1:0]] <= cfg_data_i;
      end else if (cfg_index_i == REG_AUTO_RELOAD) begin
        ar_mask_q <= cfg_data_i[AR_W-1:0];
      end else if (cfg_index_i == REG_BLINK_SLOW) begin
        blink_slow_q <= cfg_data_i;
      end else if (cfg_index_i == REG_BLINK_FAST) begin
        blink_fast_q <= cfg_data_i;
      end
    end
  end

  // sequencer
  stb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // timer state, decrementer and result register
  stb_datapath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_type_i),
    .timer_id_i   (timer_id_i),
    .fast_rate_i  (fast_rate_i),
    .period_i     (period_q),
    .ar_mask_i    (ar_mask_q[NUM_TIMERS-1:0]),
    .blink_slow_i (blink_slow_q),
    .blink_fast_i (blink_fast_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .expired_o    (expired_o),
    .remaining_o  (remaining_o),
    .running_o    (running_o),
    .led_level_o  (led_level_o),
    .id_ok_o      (id_ok_o)
  );

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the soft timer bank with led blinker: a scoreboard
// keeps its own copy of the counters and registers, predicts every result
// word, and checks each one as it leaves the block under random stalls
// ----------------------------------------------------------------------------
import stb_pkg::*;

localparam int N_TIMERS = 5;

// one result word as the block hands it off
typedef struct packed {
  logic             expired;
  logic [OUT_W-1:0] remaining;
  logic             running;
  logic             led_level;
  logic             id_ok;
} timer_word_t;

class timer_scoreboard;
  bit [CFG_W-1:0] period [N_TIMERS];
  bit [AR_W-1:0]  reload_mask;
  bit [CFG_W-1:0] blink_slow;
  bit [CFG_W-1:0] blink_fast;
  bit [CFG_W-1:0] down_cnt [N_TIMERS];
  bit             enabled [N_TIMERS];
  bit             fired [N_TIMERS];
  bit [CFG_W-1:0] led_cnt;
  bit [CFG_W-1:0] led_rel;
  bit             led_lvl;
  timer_word_t    due_q [$];
  int             checked;
  int             mismatches;
  int             ticks;
  int             expiry_hits;
  int             toggles;

  function new();
    for (int n = 0; n < N_TIMERS; n++) begin
      period[n]   = PERIOD_RESET;
      down_cnt[n] = '0;
      enabled[n]  = 1'b0;
      fired[n]    = 1'b0;
    end
    reload_mask = '0;
    blink_slow  = BLINK_SLOW_RESET;
    blink_fast  = BLINK_FAST_RESET;
    led_cnt     = BLINK_FAST_RESET;
    led_rel     = BLINK_FAST_RESET;
    led_lvl     = 1'b0;
  endfunction

  function void note_config(logic [RIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_AUTO_RELOAD: reload_mask = data[AR_W-1:0];
      REG_BLINK_SLOW:  blink_slow = data;
      REG_BLINK_FAST:  blink_fast = data;
      default:         if (idx < N_TIMERS) period[idx] = data;
    endcase
  endfunction

  function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id, logic fast);
    timer_word_t w;
    bit ok;
    int n;
    ok = (id >= 1) && (id <= N_TIMERS);
    n  = ok ? int'(id) - 1 : 0;
    w  = '0;
    case (req)
      REQ_TICK: begin
        ticks++;
        for (int t = 0; t < N_TIMERS; t++) begin
          if (enabled[t]) begin
            if (down_cnt[t] != 0) down_cnt[t]--;
            if (down_cnt[t] == 0) begin
              fired[t] = 1'b1;
              if (reload_mask[t]) down_cnt[t] = period[t];
              else enabled[t] = 1'b0;
            end
          end
        end
        if (led_cnt != 0) led_cnt--;
        if (led_cnt == 0) begin
          led_cnt = led_rel;
          led_lvl = !led_lvl;
          toggles++;
        end
      end
      REQ_START: if (ok) begin
        down_cnt[n] = period[n];
        fired[n]    = 1'b0;
        enabled[n]  = 1'b1;
      end
      REQ_STOP: if (ok) begin
        down_cnt[n] = '0;
        fired[n]    = 1'b0;
        enabled[n]  = 1'b0;
      end
      REQ_CHECK: if (ok) begin
        w.expired = fired[n];
        fired[n]  = 1'b0;
      end
      REQ_STATUS: if (ok) begin
        w.remaining = down_cnt[n];
        w.running   = enabled[n];
      end
      REQ_LED: begin
        led_rel = fast ? blink_fast : blink_slow;
        led_cnt = led_rel;
      end
      default: ;
    endcase
    w.led_level = led_lvl;
    w.id_ok     = ok;
    due_q.push_back(w);
  endfunction

  function void check_result(timer_word_t got);
    timer_word_t want;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result word with nothing expected (rem=%0d led=%0b)",
                 $realtime, got.remaining, got.led_level);
      return;
    end
    want = due_q.pop_front();
    checked++;
    if (want.expired) expiry_hits++;
    if (got.expired !== want.expired || got.remaining !== want.remaining ||
        got.running !== want.running || got.led_level !== want.led_level ||
        got.id_ok !== want.id_ok) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: word %0d exp/rem/run/led/ok want %0b/%0d/%0b/%0b/%0b got %0b/%0d/%0b/%0b/%0b",
                 $realtime, checked, want.expired, want.remaining, want.running,
                 want.led_level, want.id_ok, got.expired, got.remaining, got.running,
                 got.led_level, got.id_ok);
    end
  endfunction

  function int pending();
    return due_q.size();
  endfunction
endclass

module tb_top;

  localparam int     CLK_HALF        = 5;
  localparam int     RESET_CYCLES    = 7;
  localparam int     PHASES          = 5;
  localparam int     WORDS_PER_PHASE = 100;
  localparam int     LONG_HOLD       = 300;
  // settling tail after the last result word, longer than a tick word takes
  localparam int     TAIL_CYCLES     = 20;
  localparam longint TIMEOUT_NS      = 3_000_000;

  // request codes the block has no meaning for
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  // timer ids outside the bank
  localparam logic [ID_W-1:0]  ID_NONE      = 3'd0;
  localparam logic [ID_W-1:0]  ID_TOP       = 3'd7;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid_q  = 1'b0;
  logic [REQ_W-1:0]  req_q       = '0;
  logic [ID_W-1:0]   id_q        = '0;
  logic              fast_q      = 1'b0;
  logic              out_stall_q = 1'b0;
  logic              cfg_valid_q = 1'b0;
  logic [RIDX_W-1:0] cfg_index_q = '0;
  logic [CFG_W-1:0]  cfg_data_q  = '0;

  wire               in_stall;
  wire               out_valid;
  wire               expired;
  wire [OUT_W-1:0]   remaining;
  wire               running;
  wire               led_level;
  wire               id_ok;
  wire               cfg_ready;

  // receiver control: a long hold requested by the stimulus, and no idling at the end
  bit                hold_request = 1'b0;
  bit                quiet        = 1'b0;

  logic [CFG_W-1:0]  cfg_plan [8];
  timer_word_t       observed;
  timer_scoreboard   board;

  soft_timer_bank_with_blinker_unit #(
    .NUM_TIMERS (N_TIMERS),
    .COUNT_WIDTH(16)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall),
    .req_type_i  (req_q),
    .timer_id_i  (id_q),
    .fast_rate_i (fast_q),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall_q),
    .expired_o   (expired),
    .remaining_o (remaining),
    .running_o   (running),
    .led_level_o (led_level),
    .id_ok_o     (id_ok),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index_q),
    .cfg_data_i  (cfg_data_q)
  );

  always #CLK_HALF clk = ~clk;

  // offer one request word and hold it until the block takes it;
  // valid stays high so back-to-back words need no extra step
  task automatic send_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id, logic fast);
    in_valid_q <= 1'b1;
    req_q      <= req;
    id_q       <= id;
    fast_q     <= fast;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req, id, fast);
  endtask

  // mostly well-formed traffic: lots of ticks between starts, checks and status reads,
  // with a sprinkling of bad ids and unused request codes
  task automatic random_request();
    int r;
    logic [REQ_W-1:0] req;
    logic [ID_W-1:0] id;
    r = $urandom_range(0, 99);
    if (r < 38)      req = REQ_TICK;
    else if (r < 53) req = REQ_START;
    else if (r < 58) req = REQ_STOP;
    else if (r < 72) req = REQ_CHECK;
    else if (r < 86) req = REQ_STATUS;
    else if (r < 94) req = REQ_LED;
    else             req = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    r = $urandom_range(0, 11);
    if (r < 9)       id = ID_W'($urandom_range(1, N_TIMERS));
    else if (r < 10) id = ID_NONE;
    else             id = ID_W'($urandom_range(N_TIMERS + 1, ID_TOP));
    send_request(req, id, 1'($urandom_range(0, 1)));
    // sender-side idle burst
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_q <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // write all eight registers from cfg_plan, block must be idle
  task automatic program_registers();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_q <= 1'b1;
      cfg_index_q <= i[RIDX_W-1:0];
      cfg_data_q  <= cfg_plan[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.note_config(i[RIDX_W-1:0], cfg_plan[i]);
    end
    cfg_valid_q <= 1'b0;
  endtask

  // stop offering and wait for every outstanding result word
  task automatic drain();
    in_valid_q <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // counts for periods and led rates: small ones so expiries happen often
  function automatic logic [CFG_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      return CFG_W'($urandom_range(0, 6));
    else if (r < 85) return CFG_W'($urandom_range(7, 40));
    else if (r < 95) return CFG_W'($urandom);
    else             return '1;
  endfunction

  // result side: checks every word handed off at this edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall_q) begin
      observed.expired   = expired;
      observed.remaining = remaining;
      observed.running   = running;
      observed.led_level = led_level;
      observed.id_ok     = id_ok;
      board.check_result(observed);
    end
  end

  // result side stall: random bursts, plus one long hold so the block backs up
  initial begin : result_sink
    int n;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall_q <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        out_stall_q <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 15);
        out_stall_q <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall_q <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: timer 5 runs from the default period, led toggles after the
    // default fast count
    send_request(REQ_START, ID_W'(N_TIMERS), 1'b0);
    repeat (BLINK_FAST_RESET) send_request(REQ_TICK, ID_NONE, 1'b0);
    send_request(REQ_STATUS, ID_W'(N_TIMERS), 1'b0);
    drain();

    // extremes: zero period with reload, period of one without reload, full-scale period, zero led rate
    cfg_plan[0] = '0;
    cfg_plan[1] = 16'd1;
    cfg_plan[2] = '1;
    cfg_plan[3] = 16'd2;
    cfg_plan[4] = 16'd1;
    cfg_plan[REG_AUTO_RELOAD] = 16'h0001;
    cfg_plan[REG_BLINK_SLOW]  = '0;
    cfg_plan[REG_BLINK_FAST]  = '1;
    program_registers();
    send_request(REQ_START, 3'd1, 1'b0);
    send_request(REQ_START, 3'd2, 1'b0);
    send_request(REQ_START, 3'd3, 1'b0);
    send_request(REQ_TICK, ID_NONE, 1'b0);
    // check reports then clears
    send_request(REQ_CHECK, 3'd1, 1'b0);
    send_request(REQ_CHECK, 3'd1, 1'b0);
    send_request(REQ_STATUS, 3'd2, 1'b0);
    send_request(REQ_STATUS, 3'd3, 1'b0);
    // slow rate of zero: toggles on every tick
    send_request(REQ_LED, ID_NONE, 1'b0);
    send_request(REQ_TICK, ID_NONE, 1'b0);
    send_request(REQ_STOP, 3'd1, 1'b0);
    // ids outside the bank and unused codes change nothing
    send_request(REQ_CHECK, ID_NONE, 1'b1);
    send_request(REQ_STATUS, ID_TOP, 1'b0);
    send_request(REQ_SPARE_HI, 3'd2, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 1) begin
        // every running timer expires and reloads on each tick, led toggles each tick
        for (int i = 0; i < N_TIMERS; i++) cfg_plan[i] = '0;
        cfg_plan[REG_AUTO_RELOAD] = '1;
        cfg_plan[REG_BLINK_SLOW]  = '0;
        cfg_plan[REG_BLINK_FAST]  = '0;
      end else begin
        for (int i = 0; i < N_TIMERS; i++) cfg_plan[i] = pick_count();
        cfg_plan[REG_AUTO_RELOAD] = CFG_W'($urandom);
        cfg_plan[REG_BLINK_SLOW]  = pick_count();
        cfg_plan[REG_BLINK_FAST]  = pick_count();
      end
      program_registers();
      if (p == 2) hold_request = 1'b1;
      if (p == PHASES - 1) quiet = 1'b1;
      for (int k = 0; k < WORDS_PER_PHASE; k++) random_request();
      // the drain doubles as the sender pause until every result is back
      drain();
    end

    $display("checked %0d result words over %0d register settings: %0d ticks, %0d led toggles",
             board.checked, PHASES + 2, board.ticks, board.toggles);
    $display("expiries reported by check: %0d, mismatches: %0d",
             board.expiry_hits, board.mismatches);
    if (board.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
